>>> rtl/core/pointer_velocity_estimator_core_macros.svh
// Assertion macros for the pointer velocity estimator checker.
// Included by the checker file only.
`ifndef POINTER_VELOCITY_ESTIMATOR_CORE_MACROS_SVH
`define POINTER_VELOCITY_ESTIMATOR_CORE_MACROS_SVH
// Assert that a property holds on every clock edge outside reset.
`define PVE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert a property including during reset.
`define PVE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/core/pve_pkg.sv
// Shared constants and types for the pointer velocity estimator.
// No dependencies.
package pve_pkg;
    localparam int DEPTH_DEF = 8;
    localparam int POS_W     = 16;
    localparam int TIME_W    = 32;
    localparam int VEL_W     = 27;
    localparam int SCALE     = 1000;
    localparam int NUM_W     = 28;  // |dx*1000| < 2^27, plus sign
    localparam logic OP_START  = 1'b0;
    localparam logic OP_APPEND = 1'b1;
endpackage

>>> rtl/core/pve_div.sv
// Sequential signed divider: quotient truncated toward zero, one bit a cycle.
// Depends on pve_pkg.
module pve_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [pve_pkg::NUM_W-1:0] i_num,
    input  logic [pve_pkg::TIME_W-1:0]       i_den,
    output logic                             o_done,
    output logic signed [pve_pkg::VEL_W-1:0] o_quo
);
    localparam int NW = pve_pkg::NUM_W;
    localparam int DW = pve_pkg::TIME_W;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   w_try;
    logic [NW-1:0] w_mag;

    assign w_mag = i_num[NW-1] ? NW'(-i_num) : i_num;

    always_comb begin
        w_try = {r_rem[DW-1:0], r_q[NW-1]};
        n_q   = {r_q[NW-2:0], 1'b0};
        n_rem = w_try;
        if (w_try >= {1'b0, r_den}) begin
            n_rem = w_try - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= w_mag;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[NW-1];
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_quo = r_neg ? -pve_pkg::VEL_W'(r_q) : pve_pkg::VEL_W'(r_q);
endmodule

>>> rtl/core/pointer_velocity_estimator_core.sv
// A sample with the same time as the oldest skips the dividers. One item walks at a
// time through the two bit-serial dividers, one for x and one for y; a new item is
// taken the cycle after the result moves to the output register, even while it waits.
// Reset clears control state; the history memory is not cleared, only entries
// written in the current track are read.
module pointer_velocity_estimator_core #(
    parameter int DEPTH = pve_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // pos_x[15:0], pos_y[31:16], timestamp_ms[63:32]
    input  logic        s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // velocity_x[26:0], velocity_y[53:27], zero pad
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int PW = pve_pkg::POS_W;
    localparam int TW = pve_pkg::TIME_W;
    localparam int VW = pve_pkg::VEL_W;
    localparam int MW = 2 * PW + TW;

    localparam logic [2:0] ST_IDLE = 3'd0, ST_RDREF = 3'd1, ST_REF = 3'd2,
                           ST_RD = 3'd3, ST_CMP = 3'd4, ST_DIV = 3'd5, ST_OUT = 3'd6;

    logic [MW-1:0] r_mem [DEPTH];
    logic [MW-1:0] r_rdata;
    logic [AW-1:0] r_wslot, r_oldest, r_idx;
    logic [FW-1:0] r_fill, r_k;
    logic [2:0]    r_st;
    logic signed [PW-1:0] r_rx, r_ry;
    logic [TW-1:0] r_rt, r_dt;
    logic signed [pve_pkg::NUM_W-1:0] r_nx, r_ny;
    logic signed [VW-1:0] r_ax, r_ay;
    logic          r_dstart;
    logic          w_xdone, w_ydone;
    logic signed [VW-1:0] w_vx, w_vy;
    logic [FW-1:0] w_fill;
    logic [AW-1:0] w_slot, w_next;
    logic signed [PW-1:0] w_sx, w_sy;
    logic [TW-1:0] w_st;
    logic signed [PW:0] w_dx, w_dy;
    logic          w_load;

    assign s_axis_tready = (r_st == ST_IDLE);
    // move the result into the output register once that register is free
    assign w_load = (r_st == ST_OUT) && (!m_axis_tvalid || m_axis_tready);
    assign w_slot = (s_axis_tuser == pve_pkg::OP_START) ? '0 : r_wslot;
    assign w_next = (w_slot == AW'(DEPTH - 1)) ? '0 : w_slot + 1'b1;
    assign w_fill = (s_axis_tuser == pve_pkg::OP_START) ? FW'(1) :
                    (r_fill == FW'(DEPTH)) ? r_fill : r_fill + 1'b1;
    assign w_sx = r_rdata[PW-1:0];
    assign w_sy = r_rdata[2*PW-1:PW];
    assign w_st = r_rdata[MW-1:2*PW];
    assign w_dx = {w_sx[PW-1], w_sx} - {r_rx[PW-1], r_rx};
    assign w_dy = {w_sy[PW-1], w_sy} - {r_ry[PW-1], r_ry};

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_mem[w_slot] <= s_axis_tdata;
        r_rdata <= r_mem[r_idx];
    end

    pve_div u_div_x (.i_clk, .i_rst_n, .i_start(r_dstart), .i_num(r_nx), .i_den(r_dt),
                     .o_done(w_xdone), .o_quo(w_vx));
    pve_div u_div_y (.i_clk, .i_rst_n, .i_start(r_dstart), .i_num(r_ny), .i_den(r_dt),
                     .o_done(w_ydone), .o_quo(w_vy));

    function automatic logic signed [VW-1:0] fold(logic signed [VW-1:0] a,
                                                 logic signed [VW-1:0] v);
        logic signed [VW:0] s;
        s = {a[VW-1], a} + {v[VW-1], v};
        return (a == '0) ? v : s[VW:1];  // arithmetic shift = floor half
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_wslot <= '0; r_fill <= '0;
            m_axis_tvalid <= 1'b0; r_dstart <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (w_load) begin
                m_axis_tvalid <= 1'b1;
                m_axis_tdata  <= {2'b00, r_ay, r_ax};
            end else if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (r_st)
                ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_wslot <= w_next;
                    r_fill  <= w_fill;
                    r_oldest <= (w_fill == FW'(DEPTH)) ? w_next : '0;
                    r_idx   <= (w_fill == FW'(DEPTH)) ? w_next : '0;
                    r_ax <= '0; r_ay <= '0;
                    r_k  <= FW'(1);
                    r_st <= ST_RDREF;
                end
                ST_RDREF: r_st <= ST_REF;  // read latency
                ST_REF: begin
                    r_rx <= w_sx; r_ry <= w_sy; r_rt <= w_st;
                    if (r_k >= r_fill) r_st <= ST_OUT;
                    else begin
                        r_idx <= (r_oldest == AW'(DEPTH - 1)) ? '0 : r_oldest + 1'b1;
                        r_st  <= ST_RD;
                    end
                end
                ST_RD: r_st <= ST_CMP;
                ST_CMP: begin
                    r_dt <= w_st - r_rt;
                    r_nx <= pve_pkg::NUM_W'(w_dx * pve_pkg::SCALE);
                    r_ny <= pve_pkg::NUM_W'(w_dy * pve_pkg::SCALE);
                    if (w_st != r_rt) begin
                        r_dstart <= 1'b1;
                        r_st <= ST_DIV;
                    end else if (r_k + 1'b1 >= r_fill) r_st <= ST_OUT;
                    else begin
                        r_k <= r_k + 1'b1;
                        r_idx <= (r_idx == AW'(DEPTH - 1)) ? '0 : r_idx + 1'b1;
                        r_st <= ST_RD;
                    end
                end
                ST_DIV: if (w_xdone && w_ydone) begin
                    r_ax <= fold(r_ax, w_vx);
                    r_ay <= fold(r_ay, w_vy);
                    if (r_k + 1'b1 >= r_fill) r_st <= ST_OUT;
                    else begin
                        r_k <= r_k + 1'b1;
                        r_idx <= (r_idx == AW'(DEPTH - 1)) ? '0 : r_idx + 1'b1;
                        r_st <= ST_RD;
                    end
                end
                ST_OUT: if (w_load) r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/pve_checker.sv
// Port-level checker for the pointer velocity estimator, bound to the top level.
// Depends on pointer_velocity_estimator_core_macros.svh.
`include "pointer_velocity_estimator_core_macros.svh"
module pve_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    logic w_stall, w_take;

    assign w_stall = m_axis_tvalid && !m_axis_tready;
    assign w_take  = s_axis_tvalid && s_axis_tready;

    `PVE_ASSERT(a_out_hold, i_clk, i_rst_n, w_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "held")
    `PVE_ASSERT(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[55:54] == 2'b00, "pad set")
    `PVE_ASSERT(a_accept_gap, i_clk, i_rst_n, w_take |=> !s_axis_tready, "no work after accept")
    `PVE_ASSERT_ALWAYS(a_reset_clean, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")
endmodule

bind pointer_velocity_estimator_core pve_checker u_pve_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata
);

>>> tb/pointer_velocity_estimator_core_checker.sv
// Checker for the pointer velocity estimator: watches both stream channels,
// predicts each velocity pair from accepted samples and compares. Uses pve_pkg.
module pointer_velocity_estimator_core_checker #(
    parameter int DEPTH = pve_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data,   // pos_x, pos_y, timestamp_ms
    input  logic        i_in_user,   // opcode
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [55:0] i_out_data,  // velocity_x, velocity_y, pad
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [pve_pkg::VEL_W-1:0] vx;
        logic signed [pve_pkg::VEL_W-1:0] vy;
    } t_vel_pair;

    logic signed [pve_pkg::POS_W-1:0]  trk_x [DEPTH];
    logic signed [pve_pkg::POS_W-1:0]  trk_y [DEPTH];
    logic        [pve_pkg::TIME_W-1:0] trk_t [DEPTH];
    int unsigned next_slot;
    int unsigned sample_count;
    t_vel_pair   velocity_queue [$];

    function automatic longint half_down(longint s);
        if (s >= 0) return s / 2;
        return -((-s + 1) / 2);
    endfunction

    function automatic longint blend(longint acc, longint v);
        if (acc == 0) return v;
        return half_down(acc + v);
    endfunction

    task automatic track_sample(logic op, logic [63:0] d);
        int unsigned base, idx;
        logic [pve_pkg::TIME_W-1:0] dt;
        longint ax, ay, dx, dy;
        t_vel_pair p;
        ax = 0;
        ay = 0;
        if (op == pve_pkg::OP_START) begin
            next_slot = 0;
            sample_count = 0;
        end
        trk_x[next_slot] = d[15:0];
        trk_y[next_slot] = d[31:16];
        trk_t[next_slot] = d[63:32];
        next_slot = (next_slot + 1) % DEPTH;
        if (sample_count < DEPTH) sample_count++;
        base = (sample_count < DEPTH) ? 0 : next_slot;
        for (int k = 1; k < sample_count; k++) begin
            idx = (base + k) % DEPTH;
            dt = trk_t[idx] - trk_t[base];
            if (dt == 0) continue;
            dx = longint'(trk_x[idx]) - longint'(trk_x[base]);
            dy = longint'(trk_y[idx]) - longint'(trk_y[base]);
            ax = blend(ax, (dx * 1000) / longint'(dt));
            ay = blend(ay, (dy * 1000) / longint'(dt));
        end
        p.vx = ax[pve_pkg::VEL_W-1:0];
        p.vy = ay[pve_pkg::VEL_W-1:0];
        velocity_queue.push_back(p);
    endtask

    assign o_pending = velocity_queue.size();

    always @(posedge i_clk) begin
        t_vel_pair want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            next_slot = 0;
            sample_count = 0;
            o_fail_count <= 0;
            o_result_count <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_result_count <= o_result_count + 1;
                if (velocity_queue.size() == 0) begin
                    $error("unexpected result item %h", i_out_data);
                    errs++;
                end else begin
                    want = velocity_queue.pop_front();
                    if (i_out_data[26:0] !== want.vx) begin
                        $error("velocity_x expected %0d got %0d", want.vx,
                               $signed(i_out_data[26:0]));
                        errs++;
                    end
                    if (i_out_data[53:27] !== want.vy) begin
                        $error("velocity_y expected %0d got %0d", want.vy,
                               $signed(i_out_data[53:27]));
                        errs++;
                    end
                    if (i_out_data[55:54] !== 2'b00) begin
                        $error("pad expected 0 got %b", i_out_data[55:54]);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            if (i_in_valid && i_in_ready) track_sample(i_in_user, i_in_data);
        end
    end
endmodule

>>> tb/pointer_velocity_estimator_core_tb.sv
// Top of the pointer velocity estimator testbench: clock, reset, stimulus
// and verdict. Depends on pve_pkg, the core and the checker module.
module pointer_velocity_estimator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;  // pos_x, pos_y, timestamp_ms
    logic        s_axis_tuser = 1'b0;  // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;  // velocity_x, velocity_y, pad

    int fail_count, pending, result_count;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int sent = 0;
    int idle_cycles = 0;
    logic [31:0] clock_ms = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pointer_velocity_estimator_core i_dut (.*);

    pointer_velocity_estimator_core_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // receiver: random stalls, or a long hold-off counted here when requested
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d results outstanding", pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // valid stays high after an accept until the next item or an idle cycle
    task automatic send_sample(logic op, logic [15:0] x, logic [15:0] y, logic [31:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {t, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // one gesture: start plus appends, timestamps mostly advancing
    task automatic send_track(int n);
        logic [15:0] x, y;
        x = 16'($urandom);
        y = 16'($urandom);
        clock_ms = $urandom;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                x = 16'($urandom);
                y = 16'($urandom);
            end else begin
                x = x + 16'($urandom_range(200)) - 16'd100;
                y = y + 16'($urandom_range(200)) - 16'd100;
            end
            case ($urandom_range(9))
                0: clock_ms = clock_ms;
                1: clock_ms = $urandom;
                2: clock_ms = clock_ms + 1;
                default: clock_ms = clock_ms + $urandom_range(30);
            endcase
            send_sample(i == 0 ? pve_pkg::OP_START : pve_pkg::OP_APPEND, x, y, clock_ms);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // append straight after reset, then extremes
        send_sample(pve_pkg::OP_APPEND, 16'h0000, 16'h0000, 32'd100);
        send_sample(pve_pkg::OP_APPEND, 16'h7FFF, 16'h8000, 32'd101);
        send_sample(pve_pkg::OP_APPEND, 16'h8000, 16'h7FFF, 32'd101);
        send_sample(pve_pkg::OP_START, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
        send_sample(pve_pkg::OP_APPEND, 16'h7FFF, 16'h8000, 32'h0000_0000);
        send_sample(pve_pkg::OP_APPEND, 16'h0001, 16'hFFFF, 32'h8000_0000);
        send_sample(pve_pkg::OP_START, 16'd5, 16'd5, 32'd7);
        send_sample(pve_pkg::OP_APPEND, 16'd9, 16'd1, 32'd7);
        for (int i = 0; i < 12; i++)
            send_sample(pve_pkg::OP_APPEND, 16'(i * 37), 16'(-i * 53), 32'd8 + i[31:0]);
        send_sample(pve_pkg::OP_START, 16'hFFFF, 16'h0001, 32'hAAAA_5555);
        drain();
        repeat (250) @(posedge i_clk);

        send_idle_pct = 10;
        recv_idle_pct = 49;
        while (sent < 180) send_track($urandom_range(1, 14));
        hold_req++;
        while (sent < 200) send_track(10);
        drain();
        send_idle_pct = 49;
        recv_idle_pct = 10;
        while (sent < 360) begin
            if ($urandom_range(9) == 0)
                send_sample(1'($urandom_range(1)), 16'($urandom), 16'($urandom), $urandom);
            else
                send_track($urandom_range(1, 14));
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sent < 500) send_track($urandom_range(1, 14));

        drain();
        repeat (250) @(posedge i_clk);
        $display("covered %0d samples in start/append tracks, with wraps, repeated",
                 sent);
        $display("timestamps, extremes and stalls; %0d results checked", result_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
